/* hdl/dfpc_pkg.sv */
// ----------------------------------------------------------------------------
// dfpc_pkg
// Types and constants for the delimited frame parser with additive checksum.
// ----------------------------------------------------------------------------
package dfpc_pkg;

  localparam logic [7:0] START_BYTE = 8'h23;
  localparam logic [7:0] END_BYTE   = 8'h24;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_CMD_HI  = 3'd1,
    PH_CMD_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6,
    PH_END     = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_END_ERR  = 2'd2
  } status_e;

endpackage

/* hdl/dfpc_byte_if.sv */
// ----------------------------------------------------------------------------
// dfpc_byte_if
// Valid/ready channel carrying one received byte per request.
// ----------------------------------------------------------------------------
interface dfpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/dfpc_result_if.sv */
// ----------------------------------------------------------------------------
// dfpc_result_if
// Valid/ready channel carrying payload bytes and end-of-frame status.
// ----------------------------------------------------------------------------
interface dfpc_result_if;
  logic        valid;
  logic        ready;
  logic        is_end;
  logic [15:0] command;
  logic [15:0] frame_length;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [1:0]  status;

  modport source (
    output valid, output is_end, output command, output frame_length,
    output data_byte, output byte_index, output status, input ready
  );
  modport sink (
    input valid, input is_end, input command, input frame_length,
    input data_byte, input byte_index, input status, output ready
  );
endinterface

/* hdl/delimited_frame_parser_checksum.sv */
// ----------------------------------------------------------------------------
// delimited_frame_parser_checksum
// Frame parser: start byte, command, length, payload, checksum, end byte.
// ----------------------------------------------------------------------------
// rx_i takes one stream byte per request. The parser hunts for the start
// byte, assembles a big-endian command and length, then forwards each payload
// byte on res_o tagged with command, length and index while summing modulo
// 256. A wrong checksum, or the byte after a good checksum, yields one end
// request carrying the status (ok, checksum mismatch, bad end byte).
// Header, hunt and good-checksum bytes produce nothing on res_o.
// An accepted byte passes through the input register, then the result
// register, before it shows at res_o. Throughput: one byte per cycle
// while res_o does not stall, set by the phase update of the state machine.
// When res_o stalls, the held result stays put; the byte in the input
// register waits only if it produces a result, and rx_i backs up after that.
// Reset returns the parser to hunting and empties both registers.
// ----------------------------------------------------------------------------
module delimited_frame_parser_checksum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dfpc_byte_if.sink            rx_i,
  dfpc_result_if.source        res_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // frame state
  dfpc_pkg::phase_e phase_q, phase_d;
  logic [15:0]      cmd_q, cmd_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      count_q, count_d;
  logic [7:0]       sum_q, sum_d;

  // result register
  logic             out_valid_q;
  logic             out_is_end_q;
  logic [15:0]      out_cmd_q;
  logic [15:0]      out_len_q;
  logic [7:0]       out_data_q;
  logic [15:0]      out_idx_q;
  dfpc_pkg::status_e out_status_q;

  // combinational result
  logic              emit;
  logic              r_is_end;
  logic [7:0]        r_data;
  logic [15:0]       r_idx;
  dfpc_pkg::status_e r_status;
  logic [15:0]       len_full;
  logic              advance;

  assign len_full = {len_q[7:0], in_byte_q};

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    count_d  = count_q;
    sum_d    = sum_q;
    emit     = 1'b0;
    r_is_end = 1'b0;
    r_data   = 8'h00;
    r_idx    = count_q;
    r_status = dfpc_pkg::ST_OK;
    unique case (phase_q)
      dfpc_pkg::PH_HUNT: begin
        if (in_byte_q == dfpc_pkg::START_BYTE) phase_d = dfpc_pkg::PH_CMD_HI;
      end
      dfpc_pkg::PH_CMD_HI: begin
        cmd_d   = {8'h00, in_byte_q};
        phase_d = dfpc_pkg::PH_CMD_LO;
      end
      dfpc_pkg::PH_CMD_LO: begin
        cmd_d   = {cmd_q[7:0], in_byte_q};
        phase_d = dfpc_pkg::PH_LEN_HI;
      end
      dfpc_pkg::PH_LEN_HI: begin
        len_d   = {8'h00, in_byte_q};
        phase_d = dfpc_pkg::PH_LEN_LO;
      end
      dfpc_pkg::PH_LEN_LO: begin
        len_d   = len_full;
        count_d = '0;
        sum_d   = '0;
        // empty payload goes straight to the checksum byte
        phase_d = (len_full == 16'h0000) ? dfpc_pkg::PH_CHECK : dfpc_pkg::PH_PAYLOAD;
      end
      dfpc_pkg::PH_PAYLOAD: begin
        sum_d   = sum_q + in_byte_q;
        emit    = 1'b1;
        r_data  = in_byte_q;
        count_d = count_q + 16'd1;
        if (count_d >= len_q) phase_d = dfpc_pkg::PH_CHECK;
      end
      dfpc_pkg::PH_CHECK: begin
        if (in_byte_q == sum_q) begin
          phase_d = dfpc_pkg::PH_END;
        end else begin
          emit     = 1'b1;
          r_is_end = 1'b1;
          r_status = dfpc_pkg::ST_CSUM_ERR;
          phase_d  = dfpc_pkg::PH_HUNT;
        end
      end
      dfpc_pkg::PH_END: begin
        emit     = 1'b1;
        r_is_end = 1'b1;
        r_status = (in_byte_q == dfpc_pkg::END_BYTE) ? dfpc_pkg::ST_OK
                                                     : dfpc_pkg::ST_END_ERR;
        phase_d  = dfpc_pkg::PH_HUNT;
      end
    endcase
  end

  // a byte with no result never waits on the output side
  assign advance     = in_valid_q && (!emit || !out_valid_q || res_o.ready);
  assign rx_i.ready  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dfpc_pkg::PH_HUNT;
      cmd_q   <= '0;
      len_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_is_end_q <= r_is_end;
      out_cmd_q    <= cmd_q;
      out_len_q    <= len_q;
      out_data_q   <= r_data;
      out_idx_q    <= r_idx;
      out_status_q <= r_status;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.is_end       = out_is_end_q;
  assign res_o.command      = out_cmd_q;
  assign res_o.frame_length = out_len_q;
  assign res_o.data_byte    = out_data_q;
  assign res_o.byte_index   = out_idx_q;
  assign res_o.status       = out_status_q;

endmodule
